### sv/spm_pkg.sv
package spm_pkg;

    localparam int COEF_W  = 16;
    localparam int EXP_W   = 15;
    localparam int PCOEF_W = 38;
    localparam int PEXP_W  = 16;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int ENTRY_W = PCOEF_W + PEXP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC_RD,
        ST_ACC_CHK,
        ST_EM_RD,
        ST_EM_CHK,
        ST_EM_OUT
    } state_t;

endpackage

### sv/sparse_polynomial_multiplier.sv
// Multiplies two sparse polynomials loaded as term lists (operation 0 for the first list,
// operation 1 for the second, last closes a list; at most MAX_TERMS terms kept per list).
// Terms are loaded at one per cycle. After the closing term of the second list, in_stall
// stays high until the whole product has been delivered. Each of the first_count x
// second_count term products is merged into a product memory of PRODUCT_DEPTH entries by a
// linear search of the distinct exponents held so far in the single-port-read memory. Each
// result term then costs one full sort scan of that memory, and terms come out in strictly
// descending exponent order with final_term on the last one.
module sparse_polynomial_multiplier #(
    parameter int MAX_TERMS     = 8,
    parameter int PRODUCT_DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic signed [spm_pkg::COEF_W-1:0]      coefficient,
    input  logic [spm_pkg::EXP_W-1:0]              exponent,
    input  logic                                   last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [spm_pkg::PCOEF_W-1:0]     product_coefficient,
    output logic [spm_pkg::PEXP_W-1:0]             product_exponent,
    output logic                                   final_term
);

    import spm_pkg::*;

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (PRODUCT_DEPTH > 1) ? $clog2(PRODUCT_DEPTH) : 1;
    localparam int DW = $clog2(PRODUCT_DEPTH + 1);

    logic signed [COEF_W-1:0] first_coef_reg  [MAX_TERMS];
    logic [EXP_W-1:0]         first_exp_reg   [MAX_TERMS];
    logic signed [COEF_W-1:0] second_coef_reg [MAX_TERMS];
    logic [EXP_W-1:0]         second_exp_reg  [MAX_TERMS];

    state_t                   state_reg, state_next;
    logic [CW-1:0]            first_cnt_reg, first_cnt_next;
    logic [CW-1:0]            second_cnt_reg, second_cnt_next;
    logic                     first_done_reg, first_done_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [IW-1:0]            j_reg, j_next;
    logic [DW-1:0]            k_reg, k_next;
    logic [DW-1:0]            dist_reg, dist_next;
    logic [DW-1:0]            emit_cnt_reg, emit_cnt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [PEXP_W-1:0]        pexp_reg, pexp_next;
    logic [PEXP_W-1:0]        lim_reg, lim_next;
    logic                     lim_valid_reg, lim_valid_next;
    logic signed [PCOEF_W-1:0] best_coef_reg, best_coef_next;
    logic [PEXP_W-1:0]        best_exp_reg, best_exp_next;
    logic                     best_valid_reg, best_valid_next;

    logic                     wr_first, wr_second;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
    logic signed [PCOEF_W-1:0] rd_coef;
    logic [PEXP_W-1:0]        rd_exp;
    logic                     pair_end;

    spm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PRODUCT_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_coef = $signed(ram_rdata[ENTRY_W-1:PEXP_W]);
    assign rd_exp  = ram_rdata[PEXP_W-1:0];

    assign in_stall            = (state_reg != ST_IDLE);
    assign out_valid           = (state_reg == ST_EM_OUT);
    assign product_coefficient = best_coef_reg;
    assign product_exponent    = best_exp_reg;
    assign final_term          = ((emit_cnt_reg + DW'(1)) == dist_reg);

    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        first_done_next = first_done_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        dist_next       = dist_reg;
        emit_cnt_next   = emit_cnt_reg;
        prod_next       = prod_reg;
        pexp_next       = pexp_reg;
        lim_next        = lim_reg;
        lim_valid_next  = lim_valid_reg;
        best_coef_next  = best_coef_reg;
        best_exp_next   = best_exp_reg;
        best_valid_next = best_valid_reg;
        wr_first        = 1'b0;
        wr_second       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = k_reg[AW-1:0];
        ram_wdata       = {PCOEF_W'(prod_reg), pexp_reg};
        ram_raddr       = k_reg[AW-1:0];
        pair_end        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!operation && !first_done_reg)
                    begin
                        if (first_cnt_reg < CW'(MAX_TERMS))
                        begin
                            wr_first       = 1'b1;
                            first_cnt_next = first_cnt_reg + CW'(1);
                        end
                        if (last)
                        begin
                            first_done_next = 1'b1;
                        end
                    end
                    else if (operation && first_done_reg)
                    begin
                        if (second_cnt_reg < CW'(MAX_TERMS))
                        begin
                            wr_second       = 1'b1;
                            second_cnt_next = second_cnt_reg + CW'(1);
                        end
                        if (last)
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            dist_next  = '0;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = first_coef_reg[i_reg] * second_coef_reg[j_reg];
                pexp_next  = PEXP_W'(first_exp_reg[i_reg]) + PEXP_W'(second_exp_reg[j_reg]);
                k_next     = '0;
                state_next = ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                if (k_reg == dist_reg)
                begin
                    if (dist_reg < DW'(PRODUCT_DEPTH))
                    begin
                        ram_we    = 1'b1;
                        dist_next = dist_reg + DW'(1);
                    end
                    pair_end = 1'b1;
                end
                else
                begin
                    state_next = ST_ACC_CHK;
                end
            end
            ST_ACC_CHK:
            begin
                if (rd_exp == pexp_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_coef + PCOEF_W'(prod_reg), pexp_reg};
                    pair_end  = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + DW'(1);
                    state_next = ST_ACC_RD;
                end
            end
            ST_EM_RD:
            begin
                if (k_reg == dist_reg)
                begin
                    if (best_valid_reg)
                    begin
                        state_next = ST_EM_OUT;
                    end
                    else
                    begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        first_done_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_EM_CHK;
                end
            end
            ST_EM_CHK:
            begin
                if ((!lim_valid_reg || rd_exp < lim_reg)
                    && (!best_valid_reg || rd_exp > best_exp_reg))
                begin
                    best_coef_next  = rd_coef;
                    best_exp_next   = rd_exp;
                    best_valid_next = 1'b1;
                end
                k_next     = k_reg + DW'(1);
                state_next = ST_EM_RD;
            end
            ST_EM_OUT:
            begin
                if (!out_stall)
                begin
                    if (final_term)
                    begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        first_done_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        lim_next        = best_exp_reg;
                        lim_valid_next  = 1'b1;
                        best_valid_next = 1'b0;
                        k_next          = '0;
                        emit_cnt_next   = emit_cnt_reg + DW'(1);
                        state_next      = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next term pair or start emission
        if (pair_end)
        begin
            if (CW'(j_reg) == second_cnt_reg - CW'(1))
            begin
                j_next = '0;
                if (CW'(i_reg) == first_cnt_reg - CW'(1))
                begin
                    k_next          = '0;
                    emit_cnt_next   = '0;
                    lim_valid_next  = 1'b0;
                    best_valid_next = 1'b0;
                    state_next      = ST_EM_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_MUL;
                end
            end
            else
            begin
                j_next     = j_reg + IW'(1);
                state_next = ST_MUL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            first_done_reg <= 1'b0;
            dist_reg       <= '0;
            emit_cnt_reg   <= '0;
            lim_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            first_done_reg <= first_done_next;
            dist_reg       <= dist_next;
            emit_cnt_reg   <= emit_cnt_next;
            lim_valid_reg  <= lim_valid_next;
            best_valid_reg <= best_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        pexp_reg      <= pexp_next;
        lim_reg       <= lim_next;
        best_coef_reg <= best_coef_next;
        best_exp_reg  <= best_exp_next;
        if (wr_first)
        begin
            first_coef_reg[first_cnt_reg[IW-1:0]] <= coefficient;
            first_exp_reg[first_cnt_reg[IW-1:0]]  <= exponent;
        end
        if (wr_second)
        begin
            second_coef_reg[second_cnt_reg[IW-1:0]] <= coefficient;
            second_exp_reg[second_cnt_reg[IW-1:0]]  <= exponent;
        end
    end

endmodule

### sv/spm_ram.sv
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int MAX_TERMS     = 8;
    localparam int PRODUCT_DEPTH = 64;
    localparam logic OP_FIRST    = 1'b0;
    localparam logic OP_SECOND   = 1'b1;
    localparam int DRAIN_CYCLES  = 40000;

    typedef struct packed {
        logic                       op;
        logic signed [COEF_W-1:0]   coef;
        logic [EXP_W-1:0]           expo;
        logic                       lst;
    } term_t;

    typedef struct packed {
        logic signed [PCOEF_W-1:0]  coef;
        logic [PEXP_W-1:0]          expo;
        logic                       fin;
    } prod_term_t;

    typedef struct {
        term_t      t;
        logic       known;
        prod_term_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic [EXP_W-1:0] exponent = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [PCOEF_W-1:0] product_coefficient;
    logic [PEXP_W-1:0] product_exponent;
    logic final_term;

    sparse_polynomial_multiplier DUT (.*);

    always #5 clk = ~clk;

    // polynomial state mirror
    logic signed [COEF_W-1:0] p1_coef [MAX_TERMS];
    logic [EXP_W-1:0]         p1_exp  [MAX_TERMS];
    logic signed [COEF_W-1:0] p2_coef [MAX_TERMS];
    logic [EXP_W-1:0]         p2_exp  [MAX_TERMS];
    int   p1_count = 0;
    int   p2_count = 0;
    logic p1_closed = 1'b0;

    prod_term_t product_queue[$];
    prod_term_t known_queue[$];
    logic       has_known[$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  failed = 1'b0;

    task automatic multiply_terms(input term_t t);
        logic signed [PCOEF_W-1:0] acc_c [PRODUCT_DEPTH];
        logic [PEXP_W-1:0]         acc_e [PRODUCT_DEPTH];
        logic signed [PCOEF_W-1:0] pc;
        logic [PEXP_W-1:0]         pe;
        prod_term_t r;
        int n;
        int k;
        bit hit;
        n = 0;
        if (t.op == OP_FIRST) begin
            if (p1_closed) return;
            if (p1_count < MAX_TERMS) begin
                p1_coef[p1_count] = t.coef;
                p1_exp[p1_count] = t.expo;
                p1_count++;
            end
            if (t.lst) p1_closed = 1'b1;
            return;
        end
        if (!p1_closed) return;
        if (p2_count < MAX_TERMS) begin
            p2_coef[p2_count] = t.coef;
            p2_exp[p2_count] = t.expo;
            p2_count++;
        end
        if (!t.lst) return;
        for (int i = 0; i < p1_count; i++) begin
            for (int j = 0; j < p2_count; j++) begin
                pc = PCOEF_W'(p1_coef[i]) * PCOEF_W'(p2_coef[j]);
                pe = PEXP_W'(p1_exp[i]) + PEXP_W'(p2_exp[j]);
                hit = 1'b0;
                for (k = 0; k < n; k++) begin
                    if (acc_e[k] == pe) begin
                        acc_c[k] = acc_c[k] + pc;
                        hit = 1'b1;
                        break;
                    end
                end
                if (!hit && n < PRODUCT_DEPTH) begin
                    acc_c[n] = pc;
                    acc_e[n] = pe;
                    n++;
                end
            end
        end
        // exponents are distinct, so selection order is unique
        for (int a = 0; a < n; a++) begin
            k = a;
            for (int b = a + 1; b < n; b++)
                if (acc_e[b] > acc_e[k]) k = b;
            pc = acc_c[k]; acc_c[k] = acc_c[a]; acc_c[a] = pc;
            pe = acc_e[k]; acc_e[k] = acc_e[a]; acc_e[a] = pe;
            r.coef = acc_c[a];
            r.expo = acc_e[a];
            r.fin = (a == n - 1);
            product_queue.push_back(r);
        end
        p1_count = 0;
        p2_count = 0;
        p1_closed = 1'b0;
    endtask

    task automatic send_term(input term_t t, input logic known, input prod_term_t kr);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= t.op;
        coefficient <= t.coef;
        exponent <= t.expo;
        last <= t.lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        multiply_terms(t);
        if (known) begin
            known_queue.push_back(kr);
            has_known.push_back(1'b1);
        end
    endtask

    always @(posedge clk) begin
        prod_term_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (product_queue.size() == 0) begin
                $error("unexpected product term transaction");
                failed = 1'b1;
            end else begin
                e = product_queue.pop_front();
                if (has_known.size() > 0 && known_queue[0].fin == e.fin
                    && known_queue[0].expo == e.expo) begin
                    if (known_queue[0] != e) begin
                        $error("predictor disagrees with table row");
                        failed = 1'b1;
                    end
                    void'(known_queue.pop_front());
                    void'(has_known.pop_front());
                end
                if (product_coefficient !== e.coef) begin
                    $error("product_coefficient expected %0d actual %0d",
                           e.coef, product_coefficient);
                    failed = 1'b1;
                end
                if (product_exponent !== e.expo) begin
                    $error("product_exponent expected %0d actual %0d",
                           e.expo, product_exponent);
                    failed = 1'b1;
                end
                if (final_term !== e.fin) begin
                    $error("final_term expected %0d actual %0d", e.fin, final_term);
                    failed = 1'b1;
                end
            end
        end
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99, 0) < recv_idle_pct);
    end

    function automatic term_t mk(input logic op, input int c, input int e, input logic l);
        term_t t;
        t.op = op;
        t.coef = COEF_W'(c);
        t.expo = EXP_W'(e);
        t.lst = l;
        return t;
    endfunction

    function automatic term_t rand_term(input logic op, input logic l);
        int c;
        int e;
        case ($urandom_range(5, 0))
            0: c = $urandom_range(1, 0) ? 32767 : -32768;
            1: c = $urandom_range(6, 0) - 3;
            default: c = $urandom;
        endcase
        case ($urandom_range(4, 0))
            0: e = $urandom_range(1, 0) ? 32767 : 0;
            1: e = $urandom_range(7, 0);
            default: e = $urandom;
        endcase
        return mk(op, c, e, l);
    endfunction

    task automatic send_polynomial(input logic op, input int n);
        for (int i = 0; i < n; i++)
            send_term(rand_term(op, i == n - 1), 1'b0, '0);
    endtask

    row_t stim_table[$];

    task automatic add_row(input term_t t, input logic k, input int c, input int e,
                           input logic f);
        row_t r;
        r.t = t;
        r.known = k;
        r.r.coef = PCOEF_W'(c);
        r.r.expo = PEXP_W'(e);
        r.r.fin = f;
        stim_table.push_back(r);
    endtask

    initial begin
        int sent;
        int wait_cycles;
        // second before first list closed is ignored
        add_row(mk(OP_SECOND, 5, 3, 1'b1), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_FIRST, 32767, 32767, 1'b1), 1'b0, 0, 0, 1'b0);
        // first term after first list closed is ignored
        add_row(mk(OP_FIRST, 9, 9, 1'b0), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_SECOND, 32767, 32767, 1'b1), 1'b1, 32767 * 32767, 65534, 1'b1);
        add_row(mk(OP_FIRST, -32768, 0, 1'b1), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_SECOND, -32768, 0, 1'b1), 1'b1, 1073741824, 0, 1'b1);
        // zero sum still emitted
        add_row(mk(OP_FIRST, 1, 1, 1'b0), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_FIRST, 1, 0, 1'b1), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_SECOND, 1, 1, 1'b0), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_SECOND, -1, 0, 1'b1), 1'b1, 1, 2, 1'b0);
        // overflow of first list: 10 terms, two dropped
        for (int i = 0; i < 10; i++)
            add_row(mk(OP_FIRST, i + 1, i, i == 9), 1'b0, 0, 0, 1'b0);
        add_row(mk(OP_SECOND, 2, 100, 1'b1), 1'b1, 16, 107, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_term(stim_table[i].t, stim_table[i].known, stim_table[i].r);

        sent = stim_table.size();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 32 : 0;
            while (sent < 25 + 130 * (ph + 1)) begin
                int n1;
                int n2;
                if ($urandom_range(9, 0) == 0) begin
                    send_term(rand_term(1'($urandom), 1'($urandom)), 1'b0, '0);
                    sent++;
                end else begin
                    // mostly short lists, sometimes full or overfull
                    n1 = ($urandom_range(7, 0) == 0) ? $urandom_range(10, 7)
                                                    : $urandom_range(3, 1);
                    n2 = ($urandom_range(7, 0) == 0) ? $urandom_range(10, 7)
                                                    : $urandom_range(3, 1);
                    send_polynomial(OP_FIRST, n1);
                    send_polynomial(OP_SECOND, n2);
                    sent += n1 + n2;
                end
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (product_queue.size() > 0 && wait_cycles < 2000000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && product_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
sv/spm_pkg.sv
sv/spm_ram.sv
sv/sparse_polynomial_multiplier.sv
tb/testbench.sv
